[design/dfir_pkg.sv]
// Shared types and constants for the decimating FIR filter.
`default_nettype none

package dfir_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int PROD_W      = SAMPLE_W + COEF_W;
  localparam int ACC_W       = 40;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int TAP_W       = 7;
  localparam int TIDX_W      = 6;
  localparam int PHASE_W     = 6;
  localparam int MAX_DECIM   = 64;
  localparam int COEF_SLOTS  = 64;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECIM    = 3'd0,
    REG_TAPS     = 3'd1,
    REG_COMPLEX  = 3'd2,
    REG_TAP_IDX  = 3'd3,
    REG_TAP_RE   = 3'd4,
    REG_TAP_IM   = 3'd5
  } cfg_reg_e;

  // one queued sample and whether it triggers an output
  typedef struct packed {
    logic                emit;
    logic [SAMPLE_W-1:0] smp_im;
    logic [SAMPLE_W-1:0] smp_re;
  } smp_t;

  typedef struct packed {
    logic              we_re;
    logic              we_im;
    logic [TIDX_W-1:0] addr;
    logic [COEF_W-1:0] value;
  } coef_wr_t;

  typedef struct packed {
    logic             cplx;
    logic [TAP_W-1:0] taps;
  } mac_cfg_t;

endpackage

`default_nettype wire

[design/dfir_front.sv]
// Input side: accepts sample beats and tags each with whether its decimation phase is zero.
`default_nettype none

module dfir_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [2*dfir_pkg::SAMPLE_W-1:0] s_tdata,
  input  wire logic [dfir_pkg::TAP_W-1:0]      decim,
  input  wire logic                            q_full,
  output logic                                 push,
  output dfir_pkg::smp_t                       entry
);
  import dfir_pkg::*;

  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_next;
  logic [TAP_W-1:0]   decim_eff;
  logic [TAP_W-1:0]   phase_inc;

  always_comb begin
    if (decim == '0) begin
      decim_eff = TAP_W'(1);
    end else if (decim > TAP_W'(MAX_DECIM)) begin
      decim_eff = TAP_W'(MAX_DECIM);
    end else begin
      decim_eff = decim;
    end
    phase_inc  = {1'b0, phase} + TAP_W'(1);
    phase_next = (phase_inc >= decim_eff) ? '0 : phase_inc[PHASE_W-1:0];
  end

  assign s_tready     = !q_full;
  assign push         = s_tvalid && !q_full;
  assign entry.emit   = (phase == '0);
  assign entry.smp_re = s_tdata[SAMPLE_W-1:0];
  assign entry.smp_im = s_tdata[2*SAMPLE_W-1:SAMPLE_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (push) begin
      phase <= phase_next;
    end
  end

endmodule

`default_nettype wire

[design/dfir_queue.sv]
// Short FIFO of tagged samples between the front and the MAC engine.
`default_nettype none

module dfir_queue (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire dfir_pkg::smp_t push_data,
  output logic          full,
  input  wire logic     pop,
  output logic          empty,
  output dfir_pkg::smp_t pop_data
);
  import dfir_pkg::*;

  smp_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full     = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (QUEUE_AW+1)'(1);
        2'b01:   count <= count - (QUEUE_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/dfir_mac.sv]
// Back end: delay line and coefficient memories, one complex MAC per cycle, output register.
`default_nettype none

module dfir_mac #(
  parameter int DEPTH = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_empty,
  input  wire dfir_pkg::smp_t               q_data,
  output logic                              q_pop,
  input  wire dfir_pkg::mac_cfg_t           cfg,
  input  wire dfir_pkg::coef_wr_t           coef_wr,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [2*dfir_pkg::ACC_W-1:0]      m_tdata
);
  import dfir_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MAC   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_HOLD  = 4'b1000
  } mac_state_t;

  mac_state_t state;
  mac_state_t state_next;

  logic signed [SAMPLE_W-1:0] dmem_re [DEPTH];
  logic signed [SAMPLE_W-1:0] dmem_im [DEPTH];
  logic signed [COEF_W-1:0]   cmem_re [DEPTH];
  logic signed [COEF_W-1:0]   cmem_im [DEPTH];
  logic [DEPTH-1:0]           cval_re;
  logic [DEPTH-1:0]           cval_im;

  logic [AW-1:0]    head;
  logic [AW-1:0]    head_inc;
  logic [TAP_W-1:0] fill;
  logic [TAP_W-1:0] j;
  logic [TAP_W-1:0] taps_eff;
  logic [AW-1:0]    jj;
  logic [AW:0]      wrap_addr;
  logic [AW-1:0]    d_addr;
  logic             issue;
  logic             issue_last;
  logic             coef_in_range;

  logic signed [SAMPLE_W-1:0] dr_q, di_q;
  logic signed [COEF_W-1:0]   cr_q, ci_q;
  logic                       dval_q, crv_q, civ_q;
  logic                       s1_v, s1_last;
  logic signed [SAMPLE_W-1:0] d_re, d_im;
  logic signed [COEF_W-1:0]   c_re, c_im;

  logic signed [PROD_W-1:0] p_rr, p_ii, p_ri, p_ir;
  logic                     s2_v, s2_last;

  logic signed [ACC_W-1:0] acc_re, acc_im;
  logic                    out_load;
  logic                    start;

  assign taps_eff = (cfg.taps > TAP_W'(DEPTH)) ? TAP_W'(DEPTH) : cfg.taps;
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
  assign jj       = j[AW-1:0];
  assign wrap_addr = {1'b0, head} + (AW+1)'(DEPTH) - {1'b0, jj};
  assign d_addr   = (head >= jj) ? (head - jj) : wrap_addr[AW-1:0];

  assign q_pop      = (state == ST_IDLE) && !q_empty;
  assign start      = q_pop && q_data.emit;
  assign issue      = (state == ST_MAC);
  assign issue_last = (j == taps_eff - TAP_W'(1));
  assign out_load   = (state == ST_HOLD) && (!m_tvalid || m_tready);
  assign coef_in_range = ({1'b0, coef_wr.addr} < (TIDX_W+1)'(DEPTH));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (taps_eff == '0) ? ST_HOLD : ST_MAC;
        end
      end
      ST_MAC: begin
        if (issue_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (s2_v && s2_last) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      fill  <= '0;
      j     <= '0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        head <= head_inc;
        if (fill != TAP_W'(DEPTH)) begin
          fill <= fill + TAP_W'(1);
        end
      end
      if (start) begin
        j <= '0;
      end else if (issue) begin
        j <= j + TAP_W'(1);
      end
    end
  end

  // delay line: ring buffer, entries beyond the fill count read as zero
  always_ff @(posedge clk) begin
    if (q_pop) begin
      dmem_re[head_inc] <= q_data.smp_re;
      dmem_im[head_inc] <= q_data.smp_im;
    end
    dr_q <= dmem_re[d_addr];
    di_q <= dmem_im[d_addr];
  end

  always_ff @(posedge clk) begin
    if (coef_wr.we_re && coef_in_range) begin
      cmem_re[coef_wr.addr[AW-1:0]] <= coef_wr.value;
    end
    if (coef_wr.we_im && coef_in_range) begin
      cmem_im[coef_wr.addr[AW-1:0]] <= coef_wr.value;
    end
    cr_q <= cmem_re[jj];
    ci_q <= cmem_im[jj];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cval_re <= '0;
      cval_im <= '0;
    end else begin
      if (coef_wr.we_re && coef_in_range) begin
        cval_re[coef_wr.addr[AW-1:0]] <= 1'b1;
      end
      if (coef_wr.we_im && coef_in_range) begin
        cval_im[coef_wr.addr[AW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dval_q <= (j < fill);
    crv_q  <= cval_re[jj];
    civ_q  <= cval_im[jj];
  end

  assign d_re = dval_q ? dr_q : '0;
  assign d_im = dval_q ? di_q : '0;
  assign c_re = crv_q ? cr_q : '0;
  assign c_im = civ_q ? ci_q : '0;

  always_ff @(posedge clk) begin
    p_rr <= c_re * d_re;
    p_ii <= c_im * d_im;
    p_ri <= c_re * d_im;
    p_ir <= c_im * d_re;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= issue;
      s2_v <= s1_v;
    end
    s1_last <= issue_last;
    s2_last <= s1_last;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (s2_v) begin
      if (cfg.cplx) begin
        acc_re <= acc_re + ACC_W'(p_rr) - ACC_W'(p_ii);
        acc_im <= acc_im + ACC_W'(p_ri) + ACC_W'(p_ir);
      end else begin
        acc_re <= acc_re + ACC_W'(p_rr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {acc_im, acc_re};
    end
  end

endmodule

`default_nettype wire

[design/decimating_fir_filter.sv]
// Top level of the decimating FIR filter: config registers, front, queue and MAC engine.
//
//  channel | dir | handshake           | payload
//  s_*     | in  | s_tvalid / s_tready | s_tdata: sample_real, sample_imag
//  m_*     | out | m_tvalid / m_tready | m_tdata: acc_real, acc_imag
//  cfg_*   | in  | cfg_we              | cfg_index, cfg_data
//
// A sample that gives no output is taken by the MAC engine without running the tap loop.
// A sample that gives an output holds it for its active taps and the pipeline drain (with no
// active taps the loop is skipped), plus any wait for the output register to free up: one tap per
// cycle through a single complex multiply-accumulate unit fed by registered
// delay-line and coefficient memory reads. A 4-beat queue sits ahead of the engine.
// Reset is synchronous and takes effect at once; stored samples and taps are
// tracked by a fill count and per-tap valid bits, so no clearing pass is needed.
`default_nettype none

module decimating_fir_filter #(
  parameter int MAX_TAPS = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // [15:0] sample_real, [31:16] sample_imag
  input  wire logic [2*dfir_pkg::SAMPLE_W-1:0]   s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [39:0] acc_real, [79:40] acc_imag
  output logic [2*dfir_pkg::ACC_W-1:0]           m_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [dfir_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dfir_pkg::CFG_W-1:0]        cfg_data
);
  import dfir_pkg::*;

  localparam int DEPTH = (MAX_TAPS < COEF_SLOTS) ? MAX_TAPS : COEF_SLOTS;

  logic [TAP_W-1:0]  decim;
  logic [TAP_W-1:0]  taps;
  logic              cplx;
  logic [TIDX_W-1:0] tap_idx;

  coef_wr_t coef_wr;
  mac_cfg_t mac_cfg;

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  smp_t push_data;
  smp_t pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      decim   <= TAP_W'(1);
      taps    <= TAP_W'(1);
      cplx    <= 1'b1;
      tap_idx <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        REG_DECIM:   decim   <= cfg_data[TAP_W-1:0];
        REG_TAPS:    taps    <= cfg_data[TAP_W-1:0];
        REG_COMPLEX: cplx    <= cfg_data[0];
        REG_TAP_IDX: tap_idx <= cfg_data[TIDX_W-1:0];
        default:     ;
      endcase
    end
  end

  assign coef_wr.we_re = cfg_we && (cfg_reg_e'(cfg_index) == REG_TAP_RE);
  assign coef_wr.we_im = cfg_we && (cfg_reg_e'(cfg_index) == REG_TAP_IM);
  assign coef_wr.addr  = tap_idx;
  assign coef_wr.value = cfg_data[COEF_W-1:0];

  assign mac_cfg.cplx = cplx;
  assign mac_cfg.taps = taps;

  dfir_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .decim    (decim),
    .q_full   (q_full),
    .push     (push),
    .entry    (push_data)
  );

  dfir_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .pop_data  (pop_data)
  );

  dfir_mac #(
    .DEPTH (DEPTH)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (pop_data),
    .q_pop    (pop),
    .cfg      (mac_cfg),
    .coef_wr  (coef_wr),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

[design/dfir_chk.sv]
// Port-level checks for the decimating FIR filter, bound to the top level.
`default_nettype none

module dfir_chk (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tvalid,
  input wire logic                              s_tready,
  input wire logic [2*dfir_pkg::SAMPLE_W-1:0]   s_tdata,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [2*dfir_pkg::ACC_W-1:0]      m_tdata,
  input wire logic                              cfg_we,
  input wire logic [dfir_pkg::CFG_IDX_W-1:0]    cfg_index,
  input wire logic [dfir_pkg::CFG_W-1:0]        cfg_data
);
  import dfir_pkg::*;

  logic cplx_seen;
  logic got_input;

  always_ff @(posedge clk) begin
    if (rst) begin
      cplx_seen <= 1'b1;
      got_input <= 1'b0;
    end else begin
      if (cfg_we && (cfg_reg_e'(cfg_index) == REG_COMPLEX)) begin
        cplx_seen <= cfg_data[0];
      end
      if (s_tvalid && s_tready) begin
        got_input <= 1'b1;
      end
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output beat changed");

  a_real_imag_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !cplx_seen |-> m_tdata[2*ACC_W-1:ACC_W] == '0)
    else $error("nonzero imaginary output in real mode");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> got_input)
    else $error("output beat with no sample accepted");

endmodule

bind decimating_fir_filter dfir_chk u_dfir_chk (.*);

`default_nettype wire

[tb/fir_output_checker.sv]
// Checker for the decimating FIR filter: tracks config and samples, predicts and compares outputs.
`default_nettype none

module fir_output_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  input  wire logic                             s_tready,
  // [15:0] sample_real, [31:16] sample_imag
  input  wire logic [2*dfir_pkg::SAMPLE_W-1:0]  s_tdata,
  input  wire logic                             m_tvalid,
  input  wire logic                             m_tready,
  // [39:0] acc_real, [79:40] acc_imag
  input  wire logic [2*dfir_pkg::ACC_W-1:0]     m_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [dfir_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dfir_pkg::CFG_W-1:0]       cfg_data,
  output int                                    mismatches,
  output int                                    outstanding,
  output int                                    results_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import dfir_pkg::*;

  typedef struct packed {
    logic [ACC_W-1:0] im;
    logic [ACC_W-1:0] re;
  } acc_pair_t;

  acc_pair_t expected_acc_q[$];

  logic signed [SAMPLE_W-1:0] hist_re[COEF_SLOTS];
  logic signed [SAMPLE_W-1:0] hist_im[COEF_SLOTS];
  logic signed [COEF_W-1:0]   tap_re[COEF_SLOTS];
  logic signed [COEF_W-1:0]   tap_im[COEF_SLOTS];
  logic [TAP_W-1:0]           decim_cfg;
  logic [TAP_W-1:0]           taps_cfg;
  logic                       cplx_cfg;
  logic [TIDX_W-1:0]          tidx_cfg;
  int                         phase;

  task automatic report_mismatch(input string msg);
    $display("[%0t ns] fir check: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : track
    longint    sum_re;
    longint    sum_im;
    int        n_decim;
    int        n_taps;
    bit        emit;
    acc_pair_t want;
    acc_pair_t got;
    if (rst) begin
      decim_cfg = 7'd1;
      taps_cfg  = 7'd1;
      cplx_cfg  = 1'b1;
      tidx_cfg  = '0;
      phase     = 0;
      for (int i = 0; i < COEF_SLOTS; i++) begin
        hist_re[i] = '0;
        hist_im[i] = '0;
        tap_re[i]  = '0;
        tap_im[i]  = '0;
      end
      expected_acc_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DECIM:   decim_cfg = cfg_data[TAP_W-1:0];
          REG_TAPS:    taps_cfg  = cfg_data[TAP_W-1:0];
          REG_COMPLEX: cplx_cfg  = cfg_data[0];
          REG_TAP_IDX: tidx_cfg  = cfg_data[TIDX_W-1:0];
          REG_TAP_RE:  tap_re[tidx_cfg] = cfg_data[COEF_W-1:0];
          REG_TAP_IM:  tap_im[tidx_cfg] = cfg_data[COEF_W-1:0];
          default: ;
        endcase
      end

      if (s_tvalid && s_tready) begin
        n_decim = (decim_cfg == 0) ? 1 : (decim_cfg > MAX_DECIM) ? MAX_DECIM : int'(decim_cfg);
        n_taps  = (taps_cfg > COEF_SLOTS) ? COEF_SLOTS : int'(taps_cfg);
        for (int j = COEF_SLOTS - 1; j > 0; j--) begin
          hist_re[j] = hist_re[j-1];
          hist_im[j] = hist_im[j-1];
        end
        hist_re[0] = s_tdata[SAMPLE_W-1:0];
        hist_im[0] = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
        emit = (phase == 0);
        phase++;
        if (phase >= n_decim) phase = 0;
        if (emit) begin
          sum_re = 0;
          sum_im = 0;
          for (int j = 0; j < n_taps; j++) begin
            if (cplx_cfg) begin
              sum_re += longint'(tap_re[j]) * longint'(hist_re[j])
                      - longint'(tap_im[j]) * longint'(hist_im[j]);
              sum_im += longint'(tap_re[j]) * longint'(hist_im[j])
                      + longint'(tap_im[j]) * longint'(hist_re[j]);
            end else begin
              sum_re += longint'(tap_re[j]) * longint'(hist_re[j]);
            end
          end
          want.re = sum_re[ACC_W-1:0];
          want.im = cplx_cfg ? sum_im[ACC_W-1:0] : '0;
          expected_acc_q.push_back(want);
        end
      end

      if (m_tvalid && m_tready) begin
        got.re = m_tdata[ACC_W-1:0];
        got.im = m_tdata[2*ACC_W-1:ACC_W];
        if (expected_acc_q.size() == 0) begin
          report_mismatch($sformatf("output beat with nothing expected: re %h im %h",
                                    got.re, got.im));
        end else begin
          want = expected_acc_q.pop_front();
          results_checked++;
          if (got.re !== want.re)
            report_mismatch($sformatf("acc_real got %h expected %h", got.re, want.re));
          if (got.im !== want.im)
            report_mismatch($sformatf("acc_imag got %h expected %h", got.im, want.im));
        end
      end
    end
    outstanding = expected_acc_q.size();
  end

endmodule

`default_nettype wire

[tb/testbench.sv]
// Top of the decimating FIR filter testbench: clock, reset, stimulus, config phases and verdict.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dfir_pkg::*;

  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 450;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic [2*SAMPLE_W-1:0] s_tdata   = '0;
  logic                  m_tready  = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data  = '0;
  wire logic             s_tready;
  wire logic             m_tvalid;
  wire logic [2*ACC_W-1:0] m_tdata;

  int mismatches;
  int outstanding;
  int results_checked;
  int cycles      = 0;
  int items_sent  = 0;
  int settings    = 0;
  bit tx_steady   = 1'b0;
  bit long_hold   = 1'b0;

  decimating_fir_filter dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fir_output_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d outputs still expected", cycles, outstanding);
      $display("** decimating_fir_filter: FAILED **");
      $finish;
    end
  end

  // full-scale and sign-boundary values come up often
  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_sample(input logic [15:0] re, input logic [15:0] im);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {im, re};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    settings++;
  endtask

  initial begin : receiver
    int stall;
    int run;
    bit steady;
    run    = 0;
    steady = 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end else begin
        if (run == 0) begin
          steady = ($urandom_range(0, 3) == 0);
          run    = $urandom_range(5, 40);
        end
        run--;
        stall = steady ? 0 : $urandom_range(0, 13);
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int n;
    int n_wr;
    int rand_items;
    logic [15:0] v;
    rand_items = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset taps are all zero
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);
    wait_idle();

    write_reg(REG_TAP_RE, 16'h8000);
    write_reg(REG_TAP_IM, 16'h7FFF);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h7FFF, 16'h7FFF);
    send_sample(16'h0000, 16'hFFFF);
    wait_idle();

    for (int i = 0; i < COEF_SLOTS; i++) begin
      write_reg(REG_TAP_IDX, 16'(i));
      write_reg(REG_TAP_RE, 16'h8000);
      write_reg(REG_TAP_IM, (i % 2 == 1) ? 16'h8000 : 16'h7FFF);
    end
    write_reg(REG_TAPS, 16'd64);
    for (int i = 0; i < 6; i++)
      send_sample((i % 2 == 1) ? 16'h7FFF : 16'h8000, 16'h8000);
    wait_idle();

    // empty sum
    write_reg(REG_TAPS, 16'd0);
    send_sample(16'h1234, 16'hEDCB);
    send_sample(16'h8000, 16'h7FFF);
    wait_idle();

    // tap count saturates, real only
    write_reg(REG_TAPS, 16'd100);
    write_reg(REG_COMPLEX, 16'd0);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);
    wait_idle();

    write_reg(REG_COMPLEX, 16'd1);
    write_reg(REG_DECIM, 16'd0);
    send_sample(16'hFFFF, 16'h0001);
    send_sample(16'h0001, 16'hFFFF);
    wait_idle();

    // decimation saturates at its maximum
    write_reg(REG_DECIM, 16'd100);
    send_sample(16'h5555, 16'hAAAA);
    send_sample(16'hAAAA, 16'h5555);
    wait_idle();

    // lowered factor with the phase already past it
    write_reg(REG_DECIM, 16'd5);
    send_sample(16'h7FFF, 16'h7FFF);
    wait_idle();
    write_reg(REG_DECIM, 16'd2);
    for (int i = 0; i < 3; i++)
      send_sample(pick_value(), pick_value());
    wait_idle();

    while (rand_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       v = 16'd0;
        1:       v = 16'd64;
        2:       v = 16'($urandom_range(65, 127));
        3:       v = 16'($urandom);
        default: v = 16'($urandom_range(1, 4));
      endcase
      write_reg(REG_DECIM, v);
      case ($urandom_range(0, 9))
        0:       v = 16'd0;
        1:       v = 16'd64;
        2:       v = 16'($urandom_range(65, 127));
        3:       v = 16'($urandom);
        default: v = 16'($urandom_range(1, 8));
      endcase
      write_reg(REG_TAPS, v);
      write_reg(REG_COMPLEX, 16'($urandom));
      n_wr = $urandom_range(0, 8);
      for (int i = 0; i < n_wr; i++) begin
        if ($urandom_range(0, 3) != 0)
          write_reg(REG_TAP_IDX, ($urandom_range(0, 1) == 1) ? 16'($urandom)
                                                             : 16'($urandom_range(0, 7)));
        if ($urandom_range(0, 3) != 0)
          write_reg(REG_TAP_RE, pick_value());
        if ($urandom_range(0, 3) != 0)
          write_reg(REG_TAP_IM, pick_value());
      end
      if ($urandom_range(0, 5) == 0)
        write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));

      tx_steady = ($urandom_range(0, 3) == 0);
      n = $urandom_range(15, 45);
      if (settings == 12) begin
        // stall the output long enough to back the input up
        write_reg(REG_DECIM, 16'd1);
        long_hold = 1'b1;
        tx_steady = 1'b1;
        n = 30;
      end
      repeat (n) send_sample(pick_value(), pick_value());
      rand_items += n;
      wait_idle();
    end

    $display("run covered %0d samples over %0d register settings, %0d filter outputs checked",
             items_sent, settings, results_checked);
    $display("settings included empty and saturated tap counts, zero and saturated decimation");
    if (mismatches == 0 && outstanding == 0) begin
      $display("** decimating_fir_filter: PASSED **");
    end else begin
      $display("** decimating_fir_filter: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

[decimating_fir_filter.f]
design/dfir_pkg.sv
design/dfir_front.sv
design/dfir_queue.sv
design/dfir_mac.sv
design/decimating_fir_filter.sv
design/dfir_chk.sv
tb/fir_output_checker.sv
tb/testbench.sv
